// ----- design/tss_pkg.sv -----
`default_nettype none

package tss_pkg;

    // table and time geometry
    localparam int MAX_STEPS  = 8;
    localparam int TIME_W     = 32;
    localparam int IDX_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int STEP_W     = 4;
    localparam int CFG_W      = 4;
    localparam int LOAD_IDX_W = 3;

    // locate lanes: one for the current time, one for the last refresh
    localparam int NLANE    = 2;
    localparam int LANE_NOW = 0;
    localparam int LANE_REF = 1;

    typedef enum logic [1:0] {
        OP_START     = 2'd0,
        OP_QUERY     = 2'd1,
        OP_DISPLAYED = 2'd2,
        OP_LOAD      = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [TIME_W-1:0]       now;
        logic [LOAD_IDX_W-1:0]   load_index;
        logic [TIME_W-1:0]       load_duration;
        logic [TIME_W-1:0]       load_interval;
    } t_in_word;

    typedef struct packed {
        logic              update_needed;
        logic              running;
        logic [STEP_W-1:0] step_now;
        logic              fault;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] interval;
    } t_entry;

    typedef struct packed {
        logic             init;
        logic             data_vld;
        logic [IDX_W-1:0] idx;
    } t_walk_ctl;

    typedef logic [NLANE-1:0][TIME_W-1:0] t_lane_time;
    typedef logic [NLANE-1:0][STEP_W-1:0] t_lane_step;

endpackage

`default_nettype wire

// ----- design/tss_locate.sv -----
`default_nettype none

// walks the step table one entry per cycle, as read data arrives, for each lane, finding the step
// that holds the lane's offset from the start time
module tss_locate (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tss_pkg::t_walk_ctl        i_ctl,
    input  tss_pkg::t_lane_time       i_off_init,
    input  tss_pkg::t_entry           i_entry,
    input  logic [tss_pkg::STEP_W-1:0] i_count,
    output tss_pkg::t_lane_step       o_step,
    output logic [tss_pkg::TIME_W-1:0] o_interval
);

    logic [tss_pkg::NLANE-1:0]       r_found;
    tss_pkg::t_lane_time             r_off;
    tss_pkg::t_lane_step             r_step;
    logic [tss_pkg::TIME_W-1:0]      r_ival;
    logic [tss_pkg::NLANE-1:0]       w_hit;

    always_comb begin
        for (int l = 0; l < tss_pkg::NLANE; l++) begin
            w_hit[l]  = i_ctl.data_vld && !r_found[l] && (r_off[l] < i_entry.duration);
            o_step[l] = r_found[l] ? r_step[l] : i_count;
        end
    end

    assign o_interval = r_ival;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < tss_pkg::NLANE; l++) begin
            if (!i_rst_n) begin
                r_found[l] <= 1'b0;
            end else if (i_ctl.init) begin
                r_found[l] <= 1'b0;
                r_off[l]   <= i_off_init[l];
            end else if (w_hit[l]) begin
                r_found[l] <= 1'b1;
                r_step[l]  <= tss_pkg::STEP_W'(i_ctl.idx);
            end else if (i_ctl.data_vld && !r_found[l]) begin
                r_off[l] <= r_off[l] - i_entry.duration;
            end
        end
        // interval of the step holding the current time
        if (w_hit[tss_pkg::LANE_NOW]) begin
            r_ival <= i_entry.interval;
        end
    end

endmodule

`default_nettype wire

// ----- design/timed_step_sequencer.sv -----
`default_nettype none

// timed step sequencer: keeps a table of up to MAX_STEPS steps (duration and
// refresh interval each) in a small synchronous memory and answers one word
// out for every word in. A word is taken only while the block is idle; it
// then runs setup (start stamp, table load), walks the table one entry per
// cycle through the memory's single read port until the registered data of
// the last read has been taken, and finishes once the result has a free slot
// on the output, waiting there while the output stalls. Words that need no
// walk (anything but a start while the sequence is stopped) skip straight to
// the finish. The walk tracks the current time and the last refresh time side
// by side, so a query needs only one pass. A finished result sits in an
// output register; the block does not take a new word until that result has
// a free slot. step_count is written on its own port (always ready) and is
// expected to change only while the block is idle. There is no clearing pass
// after reset: table entries are only meaningful once loaded.
module timed_step_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tss_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tss_pkg::t_out_word          o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tss_pkg::CFG_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_WALK,
        S_FIN
    } t_state;

    // control and sequence state
    t_state                          r_state,  n_state;
    tss_pkg::t_in_word               r_item,   n_item;
    logic [tss_pkg::CFG_W-1:0]       r_step_count;
    logic                            r_run,    n_run;
    logic [tss_pkg::TIME_W-1:0]      r_start,  n_start;
    logic                            r_lrv,    n_lrv;
    logic [tss_pkg::TIME_W-1:0]      r_lrs,    n_lrs;
    logic [tss_pkg::STEP_W-1:0]      r_addr,   n_addr;
    logic                            r_pend,   n_pend;
    logic [tss_pkg::IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic                            r_out_valid, n_out_valid;
    tss_pkg::t_out_word              r_out_word,  n_out_word;

    // step table
    tss_pkg::t_entry                 r_mem [tss_pkg::MAX_STEPS];
    tss_pkg::t_entry                 r_mem_q;
    logic                            w_mem_we;
    logic                            w_rd_en;

    // walker hookup
    tss_pkg::t_walk_ctl              w_ctl;
    tss_pkg::t_lane_time             w_off_init;
    tss_pkg::t_lane_step             w_step;
    logic [tss_pkg::TIME_W-1:0]      w_ival;

    logic [tss_pkg::STEP_W-1:0]      w_active;
    logic [tss_pkg::TIME_W-1:0]      w_cur_start;
    logic                            w_out_free;
    logic                            w_in_seq;
    logic [tss_pkg::STEP_W-1:0]      w_s;
    logic [tss_pkg::STEP_W-1:0]      w_prev;

    // step_count above the table size acts as a full table
    assign w_active = (r_step_count > tss_pkg::CFG_W'(tss_pkg::MAX_STEPS))
                    ? tss_pkg::STEP_W'(tss_pkg::MAX_STEPS)
                    : tss_pkg::STEP_W'(r_step_count);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // a start moves the time base before the walk
    assign w_cur_start = (r_item.op == tss_pkg::OP_START) ? r_item.now : r_start;
    assign w_off_init[tss_pkg::LANE_NOW] = r_item.now - w_cur_start;
    assign w_off_init[tss_pkg::LANE_REF] = r_lrs - w_cur_start;

    // memory data arrives in the cycle after the read was issued
    assign w_ctl.init     = (r_state == S_PREP);
    assign w_ctl.data_vld = r_pend;
    assign w_ctl.idx      = r_pend_idx;

    assign w_s      = w_step[tss_pkg::LANE_NOW];
    assign w_prev   = w_step[tss_pkg::LANE_REF];
    assign w_in_seq = (w_s < w_active);

    tss_locate u_locate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_off_init (w_off_init),
        .i_entry    (r_mem_q),
        .i_count    (w_active),
        .o_step     (w_step),
        .o_interval (w_ival)
    );

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_run       = r_run;
        n_start     = r_start;
        n_lrv       = r_lrv;
        n_lrs       = r_lrs;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_idx  = r_addr[tss_pkg::IDX_W-1:0];
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        w_mem_we    = 1'b0;
        w_rd_en     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                case (r_item.op)
                    tss_pkg::OP_START: begin
                        n_run   = 1'b1;
                        n_start = r_item.now;
                    end
                    tss_pkg::OP_LOAD: begin
                        // write lands before the walk's first read
                        w_mem_we = (int'(r_item.load_index) < tss_pkg::MAX_STEPS);
                    end
                    default: begin
                    end
                endcase
                n_addr  = '0;
                n_state = (r_item.op == tss_pkg::OP_START || r_run) ? S_WALK : S_FIN;
            end
            S_WALK: begin
                if (r_addr < w_active) begin
                    w_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_addr  = r_addr + 1'b1;
                end else if (!r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word             = '0;
                    n_state                = S_IDLE;
                    if (!r_run) begin
                        // refresh report with no sequence running
                        n_out_word.fault = (r_item.op == tss_pkg::OP_DISPLAYED);
                    end else begin
                        n_out_word.running  = 1'b1;
                        n_out_word.step_now = w_s;
                        case (r_item.op)
                            tss_pkg::OP_QUERY: begin
                                n_out_word.update_needed = !r_lrv || !w_in_seq
                                    || (w_s != w_prev)
                                    || ((r_item.now - r_lrs) >= w_ival);
                            end
                            tss_pkg::OP_DISPLAYED: begin
                                if (w_in_seq) begin
                                    n_lrs = r_item.now;
                                    n_lrv = 1'b1;
                                end else begin
                                    // past the end: sequence stops
                                    n_run               = 1'b0;
                                    n_start             = '0;
                                    n_lrv               = 1'b0;
                                    n_lrs               = '0;
                                    n_out_word.running  = 1'b0;
                                    n_out_word.step_now = '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_count <= '0;
            r_run        <= 1'b0;
            r_start      <= '0;
            r_lrv        <= 1'b0;
            r_lrs        <= '0;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_start     <= n_start;
            r_lrv       <= n_lrv;
            r_lrs       <= n_lrs;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_step_count <= i_cfg_data;
            end
        end
        r_item     <= n_item;
        r_pend_idx <= n_pend_idx;
        r_out_word <= n_out_word;
    end

    // step table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_item.load_index[tss_pkg::IDX_W-1:0]] <= '{
                duration: r_item.load_duration,
                interval: r_item.load_interval
            };
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[r_addr[tss_pkg::IDX_W-1:0]];
        end
    end

    // a refresh record only exists while a sequence runs
    a_lrv_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lrv |-> r_run)
        else $error("refresh record valid while sequence stopped");

    // the walk never reads past the active table
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_addr <= w_active))
        else $error("table walk ran past step_count");

    // pending read data is only consumed during the walk
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_WALK))
        else $error("read data pending outside walk");

    // an accepted word always goes to setup next
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PREP))
        else $error("accepted word did not enter setup");

    // reported step never beyond the end marker
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.step_now <= w_active))
        else $error("step_now beyond step_count");

endmodule

`default_nettype wire

// ----- test/tb_timed_step_sequencer.sv -----
`timescale 1ns / 100ps

module tb_timed_step_sequencer;

    localparam int ITEM_TARGET  = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int RUN_LIMIT_NS = 6_000_000;

    // scoreboard: own copy of the sequencer state, predicts one status word
    // per accepted input word and compares it with what comes out
    class sequencer_scoreboard;
        bit [tss_pkg::TIME_W-1:0] dur [tss_pkg::MAX_STEPS];
        bit [tss_pkg::TIME_W-1:0] ivl [tss_pkg::MAX_STEPS];
        bit [tss_pkg::CFG_W-1:0]  count;
        bit                       active;
        bit [tss_pkg::TIME_W-1:0] t_start;
        bit                       refresh_ok;
        bit [tss_pkg::TIME_W-1:0] t_refresh;
        tss_pkg::t_out_word       pending_status [$];
        int                       n_errors;

        function new();
            count      = '0;
            active     = 1'b0;
            t_start    = '0;
            refresh_ok = 1'b0;
            t_refresh  = '0;
            n_errors   = 0;
            foreach (dur[i]) begin
                dur[i] = '0;
                ivl[i] = '0;
            end
        endfunction

        function void set_count(bit [tss_pkg::CFG_W-1:0] v);
            count = v;
        endfunction

        // register values above the table size act as a full table
        function int unsigned steps_in_use();
            return (count > tss_pkg::MAX_STEPS) ? tss_pkg::MAX_STEPS : count;
        endfunction

        // step holding time t, steps_in_use() once past the end
        function int unsigned step_at(bit [tss_pkg::TIME_W-1:0] t);
            bit [tss_pkg::TIME_W-1:0] off;
            int unsigned              n;
            n   = steps_in_use();
            off = t - t_start;
            for (int unsigned i = 0; i < n; i++) begin
                if (off < dur[i])
                    return i;
                off -= dur[i];
            end
            return n;
        endfunction

        function void note_item(tss_pkg::t_in_word w);
            tss_pkg::t_out_word r;
            int unsigned        s;
            r = '0;
            case (w.op)
                tss_pkg::OP_START: begin
                    active  = 1'b1;
                    t_start = w.now;
                end
                tss_pkg::OP_QUERY: begin
                    if (active) begin
                        if (!refresh_ok) begin
                            r.update_needed = 1'b1;
                        end else begin
                            s = step_at(w.now);
                            if (s >= steps_in_use() || s != step_at(t_refresh))
                                r.update_needed = 1'b1;
                            else if (bit'(w.now - t_refresh >= ivl[s]))
                                r.update_needed = 1'b1;
                        end
                    end
                end
                tss_pkg::OP_DISPLAYED: begin
                    if (!active) begin
                        r.fault = 1'b1;
                    end else if (step_at(w.now) < steps_in_use()) begin
                        t_refresh  = w.now;
                        refresh_ok = 1'b1;
                    end else begin
                        active     = 1'b0;
                        t_start    = '0;
                        refresh_ok = 1'b0;
                        t_refresh  = '0;
                    end
                end
                tss_pkg::OP_LOAD: begin
                    if (w.load_index < tss_pkg::MAX_STEPS) begin
                        dur[w.load_index] = w.load_duration;
                        ivl[w.load_index] = w.load_interval;
                    end
                end
            endcase
            r.running = active;
            if (active)
                r.step_now = tss_pkg::STEP_W'(step_at(w.now));
            pending_status.push_back(r);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
            n_errors++;
        endtask

        task check_status(tss_pkg::t_out_word got);
            tss_pkg::t_out_word want;
            if (pending_status.size() == 0) begin
                report("word with nothing pending", got, 0);
                return;
            end
            want = pending_status.pop_front();
            if (got.update_needed !== want.update_needed)
                report("update_needed", got.update_needed, want.update_needed);
            if (got.running !== want.running)
                report("running", got.running, want.running);
            if (got.step_now !== want.step_now)
                report("step_now", got.step_now, want.step_now);
            if (got.fault !== want.fault)
                report("fault", got.fault, want.fault);
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    tss_pkg::t_in_word         i_in_word;
    logic                      o_out_valid;
    logic                      i_out_stall;
    tss_pkg::t_out_word        o_out_word;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [tss_pkg::CFG_W-1:0] i_cfg_data;

    sequencer_scoreboard sb;

    int n_sent;
    bit calm;        // no gaps and no stalls while set
    int hold_asked;  // bumped by the stimulus to request a long output hold-off

    // step_count per phase, extremes included (zero, full table, above full)
    logic [tss_pkg::CFG_W-1:0] count_plan [12] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0,
                                                   4'd8, 4'd5, 4'd9, 4'd2, 4'd7,
                                                   4'd6, 4'd4};

    timed_step_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side: check every word taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_status(o_out_word);
    end

    // result side stall: random about 13 percent, or a long hold-off on request
    initial begin : out_side
        int hold_seen;
        int hold_left;
        bit calm_now;
        hold_seen   = 0;
        hold_left   = 0;
        calm_now    = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            // requests are read at the rising edge, away from the stimulus writes
            @(posedge i_clk);
            calm_now = calm;
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = !calm_now && ($urandom_range(0, 99) < 13);
            end
        end
    end

    function automatic tss_pkg::t_in_word make_word(tss_pkg::t_op op,
                                                    logic [tss_pkg::TIME_W-1:0] now,
                                                    logic [tss_pkg::LOAD_IDX_W-1:0] idx,
                                                    logic [tss_pkg::TIME_W-1:0] d,
                                                    logic [tss_pkg::TIME_W-1:0] v);
        tss_pkg::t_in_word w;
        w.op            = op;
        w.now           = now;
        w.load_index    = idx;
        w.load_duration = d;
        w.load_interval = v;
        return w;
    endfunction

    // offer one word, called and returning at a falling edge; valid stays up
    // into the next word unless that one starts with a gap
    task automatic send_word(tss_pkg::t_in_word w);
        if (!calm && $urandom_range(0, 99) < 13) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_word  = w;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(w);
        n_sent++;
        @(negedge i_clk);
    endtask

    // non-load words carry random load fields, which the block must ignore
    task automatic send_op(tss_pkg::t_op op, logic [tss_pkg::TIME_W-1:0] now);
        send_word(make_word(op, now, tss_pkg::LOAD_IDX_W'($urandom), $urandom, $urandom));
    endtask

    // sender pause until every predicted word has come out
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending_status.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_count(logic [tss_pkg::CFG_W-1:0] v);
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_count(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly short steps so sequences get walked end to end; now and then a
    // zero step (skipped) or a full 32-bit value
    function automatic logic [tss_pkg::TIME_W-1:0] pick_span(int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return $urandom;
        else
            return $urandom_range(1, top);
    endfunction

    task automatic load_table();
        for (int i = 0; i < tss_pkg::MAX_STEPS; i++)
            send_word(make_word(tss_pkg::OP_LOAD, $urandom, tss_pkg::LOAD_IDX_W'(i),
                                pick_span(60), pick_span(40)));
    endtask

    // one well-formed run: start, then queries and display updates with time
    // moving forward, until a display update past the end stops it
    task automatic run_sequence(int unsigned len);
        logic [tss_pkg::TIME_W-1:0] base;
        logic [tss_pkg::TIME_W-1:0] t;
        longint unsigned            span;
        int unsigned                stride;
        int unsigned                r;
        span = 0;
        for (int unsigned k = 0; k < sb.steps_in_use(); k++)
            span += sb.dur[k];
        stride = (span > 900) ? 150 : int'(span / 6) + 1;
        // some runs start just below the wrap point of the time counter
        if ($urandom_range(0, 9) == 0)
            base = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else
            base = $urandom;
        t = base;
        send_op(tss_pkg::OP_START, t);
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 6)
                t = base + tss_pkg::TIME_W'(span) + $urandom_range(0, 50);
            else
                t = t + $urandom_range(0, stride);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_op(tss_pkg::OP_QUERY, t);
            end else if (r < 93) begin
                send_op(tss_pkg::OP_DISPLAYED, t);
            end else if (r < 97) begin
                // restart mid-run, the refresh record stays
                base = t;
                send_op(tss_pkg::OP_START, t);
            end else begin
                send_word(make_word(tss_pkg::OP_LOAD, t, tss_pkg::LOAD_IDX_W'($urandom),
                                    $urandom_range(0, 60), $urandom_range(0, 40)));
            end
            if (!sb.active)
                break;
        end
    endtask

    // stray words: any op at any time
    task automatic send_noise();
        send_word(make_word(tss_pkg::t_op'($urandom_range(0, 3)), $urandom,
                            tss_pkg::LOAD_IDX_W'($urandom), $urandom, $urandom));
    endtask

    initial begin : stimulus
        int phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        n_sent      = 0;
        calm        = 1'b0;
        hold_asked  = 0;
        sb          = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: not running, with an empty step count after reset
        send_op(tss_pkg::OP_QUERY, 32'h0000_0000);
        send_op(tss_pkg::OP_DISPLAYED, 32'hFFFF_FFFF);
        // fill the whole table, including a zero step and all-ones values
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd0, 32'd10,         32'd4));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd1, 32'd0,          32'd7));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd2, 32'd15,         32'd0));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd3, 32'd5,          32'hFFFF_FFFF));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd4, 32'd20,         32'd3));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd5, 32'd8,          32'd5));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd6, 32'd12,         32'd2));
        send_word(make_word(tss_pkg::OP_LOAD, 0, 3'd7, 32'hFFFF_FFFF,  32'd1));
        // zero steps: running is past the end at once, a display update stops it
        send_op(tss_pkg::OP_START, 32'd100);
        send_op(tss_pkg::OP_QUERY, 32'd100);
        send_op(tss_pkg::OP_DISPLAYED, 32'd100);
        drain();
        write_count(4'd4);
        // four steps (10, 0, 15, 5) starting just below the time wrap
        send_op(tss_pkg::OP_START, 32'hFFFF_FFF0);
        send_op(tss_pkg::OP_QUERY, 32'hFFFF_FFF5);      // no refresh yet
        send_op(tss_pkg::OP_DISPLAYED, 32'hFFFF_FFF5);  // refresh in step 0
        send_op(tss_pkg::OP_QUERY, 32'hFFFF_FFF7);      // interval not yet elapsed
        send_op(tss_pkg::OP_QUERY, 32'hFFFF_FFF9);      // interval just elapsed
        send_op(tss_pkg::OP_QUERY, 32'hFFFF_FFFA);      // zero step skipped, now in step 2
        send_op(tss_pkg::OP_DISPLAYED, 32'hFFFF_FFFC);  // refresh in step 2
        send_op(tss_pkg::OP_QUERY, 32'hFFFF_FFFD);      // zero interval, always due
        send_op(tss_pkg::OP_QUERY, 32'h0000_002C);      // past the end across the wrap
        send_op(tss_pkg::OP_DISPLAYED, 32'h0000_002C);  // past the end stops the run
        send_op(tss_pkg::OP_QUERY, 32'h0000_002D);      // stopped again

        // random phases, each under its own step count
        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            drain();
            write_count(count_plan[phase % 12]);
            calm = (phase == 3);
            if (phase % 2 == 0)
                load_table();
            // long output hold-off while words keep coming, block backs up
            if (phase == 1 || phase == 7)
                hold_asked++;
            repeat (12) begin
                run_sequence($urandom_range(4, 30));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 5)) send_noise();
            end
            phase++;
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (sb.n_errors == 0 && sb.pending_status.size() == 0)
            $display("[timed_step_sequencer] OK");
        else
            $display("[timed_step_sequencer] ERROR");
        $finish;
    end

    // hang guard
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("[timed_step_sequencer] ERROR");
        $finish;
    end

endmodule
